>>> rtl/core/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types and register map constants of the real-time clock block.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // Kinds of input beat.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // Register map.
  localparam logic [6:0] ADDR_SNAP_HI  = 7'h05;
  localparam logic [6:0] ADDR_MATCH_LO = 7'h06;
  localparam logic [6:0] ADDR_MATCH_HI = 7'h0B;
  localparam logic [6:0] ADDR_LOAD_LO  = 7'h0C;
  localparam logic [6:0] ADDR_LOAD_HI  = 7'h11;
  localparam logic [6:0] ADDR_CTRL     = 7'h12;
  localparam logic [6:0] ADDR_IRQ_EN   = 7'h13;
  localparam logic [6:0] ADDR_IRQ_CLR  = 7'h14;
  localparam logic [6:0] ADDR_MASKED   = 7'h15;
  localparam logic [6:0] ADDR_RAW      = 7'h16;

  // Control register bit positions.
  localparam int unsigned CTRL_LOAD_BIT  = 0;
  localparam int unsigned CTRL_LOCK_BIT  = 1;
  localparam int unsigned CTRL_SPARE_BIT = 2;

  // Rollover points of the time-of-day counters.
  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;

  // Six counter bytes: sub-second, s, min, h, day low, day high.
  typedef logic [5:0][7:0] cnt_bytes_t;

  // One item as it is processed.
  typedef struct packed {
    logic       en;
    action_e    action;
    logic [6:0] addr;
    logic [7:0] data;
  } item_t;

  // Register file to counters.
  typedef struct packed {
    logic       tick;
    logic       load;
    cnt_bytes_t load_val;
  } cnt_ctrl_t;

  // Counters to register file: present value and value after one tick.
  typedef struct packed {
    cnt_bytes_t now;
    cnt_bytes_t next;
  } cnt_stat_t;

endpackage

>>> rtl/core/rtc_ifs.sv
// ----------------------------------------------------------------------------
// rtc_ifs
// Valid/ready channels of the real-time clock: request beats and result beats.
// ----------------------------------------------------------------------------
interface rtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] reg_addr;
  logic [7:0] write_data;

  modport source (output valid, action, reg_addr, write_data, input ready);
  modport sink   (input valid, action, reg_addr, write_data, output ready);
endinterface

interface rtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       alarm_irq;

  modport source (output valid, read_data, alarm_irq, input ready);
  modport sink   (input valid, read_data, alarm_irq, output ready);
endinterface

>>> rtl/core/rtc_time_count.sv
// ----------------------------------------------------------------------------
// rtc_time_count
// Cascaded sub-second, second, minute, hour and day counters.
// ----------------------------------------------------------------------------
module rtc_time_count
  import rtc_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cnt_ctrl_t ctrl_i,
  output cnt_stat_t stat_o
);

  localparam logic [6:0] HundLast = 7'(TICKS_PER_SECOND - 1);

  logic [6:0]  hund_q, hund_d, hund_inc;
  logic [5:0]  sec_q, sec_d, sec_inc;
  logic [5:0]  min_q, min_d, min_inc;
  logic [4:0]  hour_q, hour_d, hour_inc;
  logic [15:0] day_q, day_d, day_inc;
  logic        hund_wrap, sec_wrap, min_wrap, hour_wrap;

  always_comb begin
    hund_wrap = (hund_q >= HundLast);
    sec_wrap  = (sec_q >= SEC_LAST);
    min_wrap  = (min_q >= MIN_LAST);
    hour_wrap = (hour_q >= HOUR_LAST);

    // Value of each counter after one tick, with the carry chain applied.
    hund_inc = hund_wrap ? '0 : hund_q + 7'd1;
    sec_inc  = sec_q;
    min_inc  = min_q;
    hour_inc = hour_q;
    day_inc  = day_q;
    if (hund_wrap) begin
      sec_inc = sec_wrap ? '0 : sec_q + 6'd1;
      if (sec_wrap) begin
        min_inc = min_wrap ? '0 : min_q + 6'd1;
        if (min_wrap) begin
          hour_inc = hour_wrap ? '0 : hour_q + 5'd1;
          if (hour_wrap) begin
            day_inc = day_q + 16'd1;
          end
        end
      end
    end

    hund_d = hund_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    day_d  = day_q;
    if (ctrl_i.load) begin
      hund_d = ctrl_i.load_val[0][6:0];
      sec_d  = ctrl_i.load_val[1][5:0];
      min_d  = ctrl_i.load_val[2][5:0];
      hour_d = ctrl_i.load_val[3][4:0];
      day_d  = {ctrl_i.load_val[5], ctrl_i.load_val[4]};
    end else if (ctrl_i.tick) begin
      hund_d = hund_inc;
      sec_d  = sec_inc;
      min_d  = min_inc;
      hour_d = hour_inc;
      day_d  = day_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hund_q <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      day_q  <= '0;
    end else begin
      hund_q <= hund_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      day_q  <= day_d;
    end
  end

  assign stat_o.now  = {day_q[15:8], day_q[7:0], 3'b000, hour_q, 2'b00, min_q,
                        2'b00, sec_q, 1'b0, hund_q};
  assign stat_o.next = {day_inc[15:8], day_inc[7:0], 3'b000, hour_inc, 2'b00, min_inc,
                        2'b00, sec_inc, 1'b0, hund_inc};

  // A load takes the low bits of each load byte.
  a_load_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |=> (hund_q == $past(ctrl_i.load_val[0][6:0]))
                 && (day_q == $past({ctrl_i.load_val[5], ctrl_i.load_val[4]})))
    else $error("counter load lost");

  // A tick below the sub-second limit only increments the sub-second count.
  a_tick_no_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.tick && !ctrl_i.load && !hund_wrap)
      |=> (hund_q == $past(hund_q) + 7'd1) && $stable(sec_q) && $stable(day_q))
    else $error("unexpected carry on tick");

  // Without tick or load the time stands still.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl_i.tick && !ctrl_i.load)
      |=> $stable(hund_q) && $stable(sec_q) && $stable(min_q) && $stable(hour_q)
          && $stable(day_q))
    else $error("counters moved while idle");

endmodule

>>> rtl/core/rtc_regs.sv
// ----------------------------------------------------------------------------
// rtc_regs
// Bus register file: match, load, snapshot, control, interrupt and read mux.
// ----------------------------------------------------------------------------
module rtc_regs
  import rtc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  cnt_stat_t  stat_i,
  output cnt_ctrl_t  ctrl_o,
  output logic [7:0] rd_data_o,
  output logic       irq_o
);

  cnt_bytes_t snap_q, match_q, load_q;
  logic       spare_q, irq_en_q, irq_en_d, alarm_q, alarm_d;
  logic       is_tick, is_wr, is_rd, in_match, in_load;
  logic [2:0] match_idx, load_idx, snap_idx;

  always_comb begin
    is_tick   = item_i.en && (item_i.action == ACT_TICK);
    is_wr     = item_i.en && (item_i.action == ACT_WRITE);
    is_rd     = item_i.en && (item_i.action == ACT_READ);
    in_match  = (item_i.addr >= ADDR_MATCH_LO) && (item_i.addr <= ADDR_MATCH_HI);
    in_load   = (item_i.addr >= ADDR_LOAD_LO) && (item_i.addr <= ADDR_LOAD_HI);
    match_idx = 3'(item_i.addr - ADDR_MATCH_LO);
    load_idx  = 3'(item_i.addr - ADDR_LOAD_LO);
    snap_idx  = item_i.addr[2:0];

    ctrl_o.tick     = is_tick;
    ctrl_o.load     = is_wr && (item_i.addr == ADDR_CTRL) && item_i.data[CTRL_LOAD_BIT];
    ctrl_o.load_val = load_q;

    irq_en_d = irq_en_q;
    if (is_wr && (item_i.addr == ADDR_IRQ_EN)) begin
      irq_en_d = item_i.data[0];
    end

    // The compare sees the counters as they stand after the tick.
    alarm_d = alarm_q;
    if (is_tick && (stat_i.next == match_q)) begin
      alarm_d = 1'b1;
    end else if (is_wr && (item_i.addr == ADDR_IRQ_CLR) && item_i.data[0]) begin
      alarm_d = 1'b0;
    end

    rd_data_o = '0;
    if (is_rd) begin
      priority if (item_i.addr <= ADDR_SNAP_HI) begin
        rd_data_o = snap_q[snap_idx];
      end else if (in_match) begin
        rd_data_o = match_q[match_idx];
      end else if (in_load) begin
        rd_data_o = load_q[load_idx];
      end else if (item_i.addr == ADDR_CTRL) begin
        rd_data_o = {5'b00000, spare_q, 2'b00};
      end else if (item_i.addr == ADDR_IRQ_EN) begin
        rd_data_o = {7'b0000000, irq_en_q};
      end else if (item_i.addr == ADDR_MASKED) begin
        rd_data_o = {7'b0000000, alarm_q & irq_en_q};
      end else if (item_i.addr == ADDR_RAW) begin
        rd_data_o = {7'b0000000, alarm_q};
      end else begin
        rd_data_o = '0;
      end
    end

    irq_o = alarm_d & irq_en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q   <= '0;
      match_q  <= '0;
      load_q   <= '0;
      spare_q  <= 1'b0;
      irq_en_q <= 1'b0;
      alarm_q  <= 1'b0;
    end else begin
      irq_en_q <= irq_en_d;
      alarm_q  <= alarm_d;
      if (is_wr && in_match) begin
        match_q[match_idx] <= item_i.data;
      end
      if (is_wr && in_load) begin
        load_q[load_idx] <= item_i.data;
      end
      if (is_wr && (item_i.addr == ADDR_CTRL)) begin
        spare_q <= item_i.data[CTRL_SPARE_BIT];
        if (item_i.data[CTRL_LOCK_BIT]) begin
          snap_q <= stat_i.now;
        end
      end
    end
  end

  // Only a read returns a nonzero byte.
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_rd |-> (rd_data_o == 8'h00))
    else $error("read data on a non-read beat");

  // A clear write drops the raw alarm flag.
  a_alarm_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_wr && (item_i.addr == ADDR_IRQ_CLR) && item_i.data[0]) |=> !alarm_q)
    else $error("alarm not cleared");

  // A lock captures the counters as they were before that write.
  a_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_wr && (item_i.addr == ADDR_CTRL) && item_i.data[CTRL_LOCK_BIT])
      |=> (snap_q == $past(stat_i.now)))
    else $error("snapshot mismatch");

endmodule

>>> rtl/core/rtc_time_counter_with_alarm.sv
// ----------------------------------------------------------------------------
// rtc_time_counter_with_alarm
// Real-time clock with alarm behind a byte-wide register bus.
// ----------------------------------------------------------------------------
// Path: an accepted request goes into the input register, then its result
//   beat into the result register, where the consumer takes it.
// Throughput: one beat per cycle while the result side is ready; the
//   counter carry chain and read mux both settle between the registers.
// Reset: asynchronous and active low; all counters, match, load and snapshot
//   bytes, control bits and the alarm flag clear at once, with no sweep.
// ----------------------------------------------------------------------------
module rtc_time_counter_with_alarm
  import rtc_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rtc_in_if.sink       in_i,
  rtc_out_if.source    out_o
);

  // The input register holds one request beat. It is processed against the
  // block state in the cycle it moves into the result register, so the state
  // is always up to date for the beat behind it; beats can go back to back.
  logic       in_valid_q;
  logic [1:0] action_q;
  logic [6:0] addr_q;
  logic [7:0] data_q;

  // The result register parts the bus side from the downstream consumer.
  logic       out_valid_q;
  logic [7:0] rd_q;
  logic       irq_q;

  logic       advance;
  logic       in_take;
  item_t      item;
  cnt_ctrl_t  cnt_ctrl;
  cnt_stat_t  cnt_stat;
  logic [7:0] rd_d;
  logic       irq_d;

  // The head beat moves on when the result slot is empty or being emptied.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;

  always_comb begin
    item.en     = advance;
    item.action = action_e'(action_q);
    item.addr   = addr_q;
    item.data   = data_q;
  end

  rtc_time_count #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_count (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cnt_ctrl),
    .stat_o (cnt_stat)
  );

  rtc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .stat_i    (cnt_stat),
    .ctrl_o    (cnt_ctrl),
    .rd_data_o (rd_d),
    .irq_o     (irq_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= in_i.action;
      addr_q   <= in_i.reg_addr;
      data_q   <= in_i.write_data;
    end
    if (advance) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = rd_q;
  assign out_o.alarm_irq = irq_q;

  // Backpressure reaches the request side only when both registers are full.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && out_valid_q && !out_o.ready))
    else $error("request side stalled without cause");

  // Every processed beat lands in the result register.
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed beat lost");

  // An accepted beat is either processed next cycle or still waiting.
  a_take_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted beat dropped");

endmodule

>>> tb/sv/rtc_time_counter_with_alarm_checker.sv
// ----------------------------------------------------------------------------
// rtc_time_counter_with_alarm_checker
// Watches both channels of the clock block and predicts every result beat.
// It keeps its own copy of the counters and registers, and it compares each
// result beat with the oldest prediction that is still open.
// ----------------------------------------------------------------------------
module rtc_time_counter_with_alarm_checker
  import rtc_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtc_in_if           req_i,
  rtc_out_if          rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // The enable, clear and status registers all use bit 0.
  localparam int unsigned FLAG_BIT = 0;

  typedef struct packed {
    logic [7:0] read_data;
    logic       alarm_irq;
  } readout_t;

  logic [6:0]  sub_sec;
  logic [5:0]  sec_cnt;
  logic [5:0]  min_cnt;
  logic [4:0]  hour_cnt;
  logic [15:0] day_cnt;
  cnt_bytes_t  snap_bytes;
  cnt_bytes_t  match_bytes;
  cnt_bytes_t  load_bytes;
  logic        spare_bit;
  logic        irq_en;
  logic        alarm_flag;
  readout_t    open_readouts[$];
  int unsigned mismatch_total;

  function automatic cnt_bytes_t time_bytes();
    return {day_cnt, 3'b000, hour_cnt, 2'b00, min_cnt, 2'b00, sec_cnt, 1'b0, sub_sec};
  endfunction

  // Returns the carry out and the next value of one counter stage.
  function automatic logic [8:0] roll(logic [7:0] value, logic [7:0] last);
    if (value >= last) begin
      return {1'b1, 8'h00};
    end
    return {1'b0, value + 8'd1};
  endfunction

  task automatic tick_clock();
    logic [8:0] stage;
    stage = roll({1'b0, sub_sec}, 8'(TICKS_PER_SECOND - 1));
    sub_sec = stage[6:0];
    if (stage[8]) begin
      stage = roll({2'b00, sec_cnt}, {2'b00, SEC_LAST});
      sec_cnt = stage[5:0];
      if (stage[8]) begin
        stage = roll({2'b00, min_cnt}, {2'b00, MIN_LAST});
        min_cnt = stage[5:0];
        if (stage[8]) begin
          stage = roll({3'b000, hour_cnt}, {3'b000, HOUR_LAST});
          hour_cnt = stage[4:0];
          if (stage[8]) begin
            day_cnt = day_cnt + 16'd1;
          end
        end
      end
    end
    if (time_bytes() == match_bytes) begin
      alarm_flag = 1'b1;
    end
  endtask

  task automatic write_register(input logic [6:0] addr, input logic [7:0] data);
    int idx;
    idx = int'(addr);
    if (addr >= ADDR_MATCH_LO && addr <= ADDR_MATCH_HI) begin
      match_bytes[idx - int'(ADDR_MATCH_LO)] = data;
    end else if (addr >= ADDR_LOAD_LO && addr <= ADDR_LOAD_HI) begin
      load_bytes[idx - int'(ADDR_LOAD_LO)] = data;
    end else if (addr == ADDR_CTRL) begin
      spare_bit = data[CTRL_SPARE_BIT];
      // The snapshot sees the counters as they were before any load.
      if (data[CTRL_LOCK_BIT]) begin
        snap_bytes = time_bytes();
      end
      if (data[CTRL_LOAD_BIT]) begin
        sub_sec  = load_bytes[0][6:0];
        sec_cnt  = load_bytes[1][5:0];
        min_cnt  = load_bytes[2][5:0];
        hour_cnt = load_bytes[3][4:0];
        day_cnt  = {load_bytes[5], load_bytes[4]};
      end
    end else if (addr == ADDR_IRQ_EN) begin
      irq_en = data[FLAG_BIT];
    end else if (addr == ADDR_IRQ_CLR) begin
      if (data[FLAG_BIT]) begin
        alarm_flag = 1'b0;
      end
    end
  endtask

  function automatic logic [7:0] read_register(logic [6:0] addr);
    logic [7:0] value;
    int         idx;
    value = 8'h00;
    idx   = int'(addr);
    if (addr <= ADDR_SNAP_HI) begin
      value = snap_bytes[idx];
    end else if (addr >= ADDR_MATCH_LO && addr <= ADDR_MATCH_HI) begin
      value = match_bytes[idx - int'(ADDR_MATCH_LO)];
    end else if (addr >= ADDR_LOAD_LO && addr <= ADDR_LOAD_HI) begin
      value = load_bytes[idx - int'(ADDR_LOAD_LO)];
    end else if (addr == ADDR_CTRL) begin
      value[CTRL_SPARE_BIT] = spare_bit;
    end else if (addr == ADDR_IRQ_EN) begin
      value[FLAG_BIT] = irq_en;
    end else if (addr == ADDR_MASKED) begin
      value[FLAG_BIT] = alarm_flag & irq_en;
    end else if (addr == ADDR_RAW) begin
      value[FLAG_BIT] = alarm_flag;
    end
    return value;
  endfunction

  task automatic predict_beat(input logic [1:0] act, input logic [6:0] addr,
                              input logic [7:0] data, output readout_t result);
    result.read_data = 8'h00;
    case (act)
      ACT_TICK: begin
        tick_clock();
      end
      ACT_WRITE: begin
        write_register(addr, data);
      end
      ACT_READ: begin
        result.read_data = read_register(addr);
      end
      default: begin
      end
    endcase
    result.alarm_irq = alarm_flag & irq_en;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    readout_t want;
    readout_t got;
    if (!rst_ni) begin
      sub_sec     = '0;
      sec_cnt     = '0;
      min_cnt     = '0;
      hour_cnt    = '0;
      day_cnt     = '0;
      snap_bytes  = '0;
      match_bytes = '0;
      load_bytes  = '0;
      spare_bit   = 1'b0;
      irq_en      = 1'b0;
      alarm_flag  = 1'b0;
      open_readouts.delete();
      mismatch_total = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      // A result accepted now belongs to an older request, so pop first.
      if (rsp_i.valid && rsp_i.ready) begin
        if (open_readouts.size() == 0) begin
          $display("%0t: result beat with nothing expected: read_data 0x%02h alarm_irq %0b",
                   $time, rsp_i.read_data, rsp_i.alarm_irq);
          mismatch_total++;
        end else begin
          want = open_readouts.pop_front();
          if (rsp_i.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected 0x%02h, actual 0x%02h",
                     $time, want.read_data, rsp_i.read_data);
            mismatch_total++;
          end
          if (rsp_i.alarm_irq !== want.alarm_irq) begin
            $display("%0t: alarm_irq mismatch: expected %0b, actual %0b",
                     $time, want.alarm_irq, rsp_i.alarm_irq);
            mismatch_total++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_beat(req_i.action, req_i.reg_addr, req_i.write_data, got);
        open_readouts.push_back(got);
      end
      mismatch_count_o <= mismatch_total;
      pending_o        <= open_readouts.size();
    end
  end

endmodule

>>> tb/sv/rtc_time_counter_with_alarm_test.sv
// ----------------------------------------------------------------------------
// rtc_time_counter_with_alarm_test
// Stimulus and verdict for the real-time clock with alarm.
// A directed opening covers the register map edges, over-range loads, lock
// with load, the day wrap and the alarm flag; random scenarios then set up
// alarms, rollovers and register traffic with random gaps on both channels.
// ----------------------------------------------------------------------------
module rtc_time_counter_with_alarm_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rtc_pkg::*;

  localparam int unsigned TICKS        = 100;
  localparam int unsigned RANDOM_ITEMS = 1100;
  // Snapshot bytes start at the bottom of the map; the package only names
  // the top one.
  localparam logic [6:0] SNAP_LO    = 7'h00;
  // Highest address, always unused.
  localparam logic [6:0] ADDR_TOP   = 7'h7F;
  // The action code that the block does not use.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  rtc_in_if  in_bus ();
  rtc_out_if out_bus ();

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned useful_beats;
  bit          steady_phase;

  rtc_time_counter_with_alarm #(
    .TICKS_PER_SECOND(TICKS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  rtc_time_counter_with_alarm_checker #(
    .TICKS_PER_SECOND(TICKS)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (in_bus),
    .rsp_i           (out_bus),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // The result side stalls at random, except during steady phases, where it
  // keeps ready high so that beats stream back to back.
  initial begin : result_sink
    int unsigned hold;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = steady_phase ? 0 : pick_gap();
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Offer one request beat and hold it until the block takes it. The caller
  // either sends the next beat in the same step or lowers valid by draining,
  // so valid never sees two assignments in one step.
  task automatic send_beat(input logic [1:0] act, input logic [6:0] addr,
                           input logic [7:0] data);
    int unsigned gap;
    bit          ignored;
    gap = steady_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.action     <= act;
    in_bus.reg_addr   <= addr;
    in_bus.write_data <= data;
    do @(posedge clk_i); while (!in_bus.ready);
    // Writes to read-only or unused addresses and the unused action change
    // nothing, so they do not count toward the random item budget.
    ignored = (act == ACT_UNUSED) ||
              (act == ACT_WRITE && (addr <= ADDR_SNAP_HI || addr >= ADDR_MASKED));
    if (!ignored) begin
      useful_beats++;
    end
  endtask

  task automatic write_reg(input logic [6:0] addr, input logic [7:0] data);
    send_beat(ACT_WRITE, addr, data);
  endtask

  task automatic read_reg(input logic [6:0] addr);
    send_beat(ACT_READ, addr, 8'($urandom));
  endtask

  task automatic tick_n(input int unsigned count);
    repeat (count) send_beat(ACT_TICK, 7'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait until every predicted result beat has come back.
  // It always waits on the clock before it returns, so valid is never
  // assigned twice in one step.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic load_counters(input cnt_bytes_t value, input logic [7:0] ctrl_extra);
    for (int i = 0; i < 6; i++) begin
      write_reg(7'(ADDR_LOAD_LO + i), value[i]);
    end
    write_reg(ADDR_CTRL, ctrl_extra | 8'(1 << CTRL_LOAD_BIT));
  endtask

  function automatic logic [15:0] pick_day();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed opening. After reset every match byte is zero, so the tick
  // that wraps all counters to zero (and the day count past 0xFFFF) must
  // raise the alarm.
  task automatic run_directed();
    read_reg(ADDR_RAW);
    // Load bytes wider than their counters; each counter keeps only its
    // low bits, and all of them start at or beyond their last value.
    for (int i = 0; i < 6; i++) begin
      write_reg(7'(ADDR_LOAD_LO + i), 8'hFF);
    end
    // Lock and load in one write: the snapshot must hold the old zeros.
    write_reg(ADDR_CTRL, 8'hFF);
    read_reg(ADDR_CTRL);
    read_reg(ADDR_SNAP_HI);
    tick_n(1);
    write_reg(ADDR_CTRL, 8'(1 << CTRL_LOCK_BIT));
    read_reg(SNAP_LO);
    read_reg(ADDR_RAW);
    // The alarm was raised with the interrupt masked; unmask it now.
    write_reg(ADDR_IRQ_EN, 8'hFF);
    read_reg(ADDR_IRQ_EN);
    // A clear write with bit 0 low leaves the flag alone.
    write_reg(ADDR_IRQ_CLR, 8'hFE);
    read_reg(ADDR_MASKED);
    write_reg(ADDR_IRQ_CLR, 8'h01);
    write_reg(ADDR_MATCH_HI, 8'hFF);
    read_reg(ADDR_MATCH_HI);
    // Writes to a read-only register and to an unused one are dropped.
    write_reg(SNAP_LO, 8'hA5);
    read_reg(SNAP_LO);
    write_reg(ADDR_TOP, 8'hFF);
    read_reg(ADDR_TOP);
    send_beat(ACT_UNUSED, ADDR_TOP, 8'hFF);
  endtask

  // Load the counters a few ticks short of the match value, then tick past
  // it. One case in three starts at the very end of a day, so the alarm
  // fires on the tick that carries through every stage.
  task automatic run_alarm_case();
    cnt_bytes_t  start_val;
    cnt_bytes_t  alarm_val;
    logic [15:0] day;
    int unsigned lead;
    logic [7:0]  ctrl_extra;
    day = pick_day();
    if ($urandom_range(0, 2) == 0) begin
      start_val = {day, 3'b000, HOUR_LAST, 2'b00, MIN_LAST, 2'b00, SEC_LAST,
                   8'(TICKS - 1)};
      day       = day + 16'd1;
      alarm_val = {day, 32'h0};
      lead      = 1;
    end else begin
      lead         = $urandom_range(1, 8);
      start_val[0] = 8'($urandom_range(0, TICKS - 1 - lead));
      start_val[1] = 8'($urandom_range(0, 59));
      start_val[2] = 8'($urandom_range(0, 59));
      start_val[3] = 8'($urandom_range(0, 23));
      start_val[4] = day[7:0];
      start_val[5] = day[15:8];
      alarm_val    = start_val;
      alarm_val[0] = start_val[0] + 8'(lead);
    end
    for (int i = 0; i < 6; i++) begin
      write_reg(7'(ADDR_MATCH_LO + i), alarm_val[i]);
    end
    // Mostly enabled, so the interrupt output is exercised in both states.
    write_reg(ADDR_IRQ_EN, {7'($urandom), 1'($urandom_range(0, 3) != 0)});
    ctrl_extra = 8'($urandom);
    load_counters(start_val, ctrl_extra);
    write_reg(ADDR_IRQ_CLR, 8'($urandom) | 8'h01);
    for (int i = 0; i < int'(lead) + $urandom_range(0, 3); i++) begin
      tick_n(1);
      if ($urandom_range(0, 3) == 0) begin
        read_reg($urandom_range(0, 1) ? ADDR_RAW : ADDR_MASKED);
      end
    end
    read_reg(ADDR_RAW);
    read_reg(ADDR_MASKED);
    write_reg(ADDR_CTRL, 8'(1 << CTRL_LOCK_BIT));
    read_reg(7'($urandom_range(0, 5)));
    if ($urandom_range(0, 1) == 0) begin
      write_reg(ADDR_IRQ_CLR, 8'($urandom) | 8'h01);
    end
  endtask

  // Start counters on, near or beyond their last values and tick through
  // the carries, then read the whole snapshot back in random order.
  task automatic run_rollover_case();
    cnt_bytes_t value;
    logic [7:0] limits [6];
    int         order [6];
    int         j;
    int         tmp;
    limits = '{8'(TICKS - 1), 8'(SEC_LAST), 8'(MIN_LAST), 8'(HOUR_LAST), 8'hFF, 8'hFF};
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        value[i] = 8'($urandom);
      end else begin
        value[i] = limits[i] - 8'($urandom_range(0, 2));
      end
      order[i] = i;
    end
    // Lock may ride along with the load; the snapshot then holds old time.
    load_counters(value, $urandom_range(0, 1) ? 8'(1 << CTRL_LOCK_BIT) : 8'h00);
    tick_n($urandom_range(0, 4) == 0 ? $urandom_range(100, 130) : $urandom_range(1, 6));
    write_reg(ADDR_CTRL, 8'($urandom) & ~8'(1 << CTRL_LOAD_BIT) | 8'(1 << CTRL_LOCK_BIT));
    for (int i = 5; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 6; i++) begin
      read_reg(7'(order[i]));
    end
  endtask

  // Write any read/write register and read it back. Control writes with
  // random data may also lock or load, which the checker follows.
  task automatic run_readback_case();
    logic [6:0] addr;
    repeat ($urandom_range(1, 4)) begin
      addr = 7'($urandom_range(ADDR_MATCH_LO, ADDR_IRQ_EN));
      write_reg(addr, 8'($urandom));
      read_reg(addr);
    end
    if ($urandom_range(0, 2) == 0) begin
      read_reg(ADDR_IRQ_CLR);
    end
  endtask

  task automatic run_tick_run();
    tick_n($urandom_range(0, 4) == 0 ? $urandom_range(100, 220) : $urandom_range(5, 40));
    write_reg(ADDR_CTRL, 8'(1 << CTRL_LOCK_BIT));
    read_reg(SNAP_LO + 7'd1);
    read_reg(SNAP_LO);
  endtask

  // Unstructured traffic over the whole address space, the unused action
  // included.
  task automatic run_noise();
    logic [1:0] act;
    logic [6:0] addr;
    repeat ($urandom_range(3, 12)) begin
      act  = ($urandom_range(0, 99) < 4) ? ACT_UNUSED : 2'($urandom_range(0, 2));
      addr = $urandom_range(0, 1) ? 7'($urandom_range(0, ADDR_RAW + 1)) : 7'($urandom);
      send_beat(act, addr, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned pick;
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.action      <= ACT_TICK;
    in_bus.reg_addr    <= '0;
    in_bus.write_data  <= '0;
    steady_phase       <= 1'b0;
    useful_beats        = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    // Let the pipeline run dry once before the random part.
    drain();

    base = useful_beats;
    while (useful_beats - base < RANDOM_ITEMS) begin
      steady_phase <= ($urandom_range(0, 6) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        run_alarm_case();
      end else if (pick < 55) begin
        run_rollover_case();
      end else if (pick < 70) begin
        run_readback_case();
      end else if (pick < 85) begin
        run_tick_run();
      end else begin
        run_noise();
      end
      if ($urandom_range(0, 9) == 0) begin
        drain();
      end
    end

    // Everything is sent; wait for the last results, then keep the clock running
    // so that any stray result beat is seen by the checker.
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // A correct run takes a few milliseconds at most, stalls included.
  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d result beats still expected", pending);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rtc_pkg.sv
rtl/core/rtc_ifs.sv
rtl/core/rtc_time_count.sv
rtl/core/rtc_regs.sv
rtl/core/rtc_time_counter_with_alarm.sv
tb/sv/rtc_time_counter_with_alarm_checker.sv
tb/sv/rtc_time_counter_with_alarm_test.sv
